// ===== src/sem_pkg.sv =====
`timescale 1ns / 1ps
package sem_pkg;
   localparam int PIX_W = 24;
   localparam int CFG_W = 13;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   // Item sequencer of the core
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_WIN,
      S_CALC,
      S_HOLD
   } seq_state_type;

   // Per-pixel control that travels from the line stage to the magnitude stage
   typedef struct packed {
      logic       emit;
      logic       last;
      logic [2:0] keep_row;
      logic [2:0] keep_col;
   } win_ctrl_type;
endpackage

// ===== src/sem_if.sv =====
`timescale 1ns / 1ps
interface sem_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic       blank;
   modport source (output valid, red_in, green_in, blue_in, blank, input ready);
   modport sink (input valid, red_in, green_in, blue_in, blank, output ready);
endinterface

interface sem_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_edge;
   logic [7:0] green_edge;
   logic [7:0] blue_edge;
   logic       frame_end;
   modport source (output valid, red_edge, green_edge, blue_edge, frame_end, input ready);
   modport sink (input valid, red_edge, green_edge, blue_edge, frame_end, output ready);
endinterface

// ===== src/sem_line_store.sv =====
`timescale 1ns / 1ps
// Two line memories, one read port and one write port each, read data registered.
module sem_line_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [AW-1:0]            rd_addr,
   output logic [sem_pkg::PIX_W-1:0] upper_rd,
   output logic [sem_pkg::PIX_W-1:0] middle_rd,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [sem_pkg::PIX_W-1:0] upper_wr,
   input  logic [sem_pkg::PIX_W-1:0] middle_wr
);
   logic [sem_pkg::PIX_W-1:0] upper_mem [DEPTH];
   logic [sem_pkg::PIX_W-1:0] middle_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= upper_wr;
         middle_mem[wr_addr] <= middle_wr;
      end
      if (rd_en) begin
         upper_rd  <= upper_mem[rd_addr];
         middle_rd <= middle_mem[rd_addr];
      end
   end
endmodule

// ===== src/sem_magnitude.sv =====
`timescale 1ns / 1ps
// One channel: Sobel gradients, then an 8-step integer root over cycles.
module sem_magnitude (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [71:0] win,      // 9 x 8 bit, tap k at [8k+7:8k], already masked
   output logic        done,
   output logic [7:0]  edge_out
);
   logic signed [11:0] gx, gy;
   logic [20:0]        sum_sq_ff, sum_sq_in;
   logic [7:0]         root_ff, root_in;
   logic [3:0]         step_ff, step_in;
   logic               busy_ff, busy_in;
   logic [7:0]         trial;
   logic [15:0]        trial_sq;
   logic [20:0]        rem;
   logic [7:0]         res_ff, res_in;
   logic               done_ff, done_in;

   function automatic logic signed [11:0] tap(input logic [71:0] w, input int k);
      return signed'({4'd0, w[8*k +: 8]});
   endfunction

   // Gradients from the masked window
   always_comb begin
      gx = (tap(win,2) - tap(win,0)) + ((tap(win,5) - tap(win,3)) <<< 1)
         + (tap(win,8) - tap(win,6));
      gy = (tap(win,6) - tap(win,0)) + ((tap(win,7) - tap(win,1)) <<< 1)
         + (tap(win,8) - tap(win,2));
   end

   // Restoring root, one bit per cycle, then rounding
   always_comb begin
      sum_sq_in = sum_sq_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      res_in    = res_ff;
      done_in   = 1'b0;
      trial     = root_ff | (8'd1 << step_ff[2:0]);
      trial_sq  = trial * trial;
      rem       = sum_sq_ff - 21'(root_ff) * 21'(root_ff);
      if (start) begin
         // squares are taken at full width before they are summed
         sum_sq_in = 21'(24'(gx) * 24'(gx)) + 21'(24'(gy) * 24'(gy));
         root_in   = '0;
         step_in   = 4'd7;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (sum_sq_ff > 21'd65280)
               res_in = 8'd255;
            else if (rem > 21'(root_ff))
               res_in = root_ff + 8'd1;
            else
               res_in = root_ff;
         end else begin
            if (21'(trial_sq) <= sum_sq_ff)
               root_in = trial;
            step_in = step_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sum_sq_ff <= sum_sq_in;
      root_ff   <= root_in;
      step_ff   <= step_in;
      res_ff    <= res_in;
   end

   assign done     = done_ff;
   assign edge_out = res_ff;
endmodule

// ===== src/sobel_edge_magnitude_core.sv =====
`timescale 1ns / 1ps
// Sobel 3x3 edge magnitude over an RGB raster stream.
// req: one pixel (or blank flush item) per transaction, raster order.
// rsp: per-channel round(sqrt(gx^2+gy^2)) clamped to 255, frame_end on last.
// The result for a pixel appears with the transaction W+1 items later; after
// a frame the source sends W+1 blank items to flush it out.
// An item that yields a result passes the accept state, a line-memory read
// state, a window state that starts the channel units, the bit-serial root
// (8 steps plus rounding) and the done register; the result is then loaded
// into the output register that drives rsp.valid. An item whose window lies
// outside the frame leaves after the window state. The output register parts
// the two sides: while rsp is stalled the core still takes and computes the
// next item, and holds that finished result until the output register frees
// up; only then is req blocked.
// csr: write enable, index (0 width, 1 height), data; a write restarts the
// frame position. Reset sets width 640, height 480, position zero, empty
// window and empty output. Line memory contents are undefined until written;
// rows that read them are outside the frame and masked.
module sobel_edge_magnitude_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   sem_req_if.sink                   req,
   sem_rsp_if.source                 rsp,
   input  logic                      csr_write,
   input  logic [0:0]                csr_index,
   input  logic [sem_pkg::CFG_W-1:0] csr_data
);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1) + 1;
   localparam int AW = $clog2(MAX_WIDTH);

   sem_pkg::seq_state_type st_ff, st_in;
   logic [11:0] width_ff;
   logic [12:0] height_ff;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] w_eff, cur_col;
   logic [RW-1:0] h_eff;
   logic [sem_pkg::PIX_W-1:0] px_ff;
   logic [sem_pkg::PIX_W-1:0] win_ff [9];
   logic [sem_pkg::PIX_W-1:0] upper_rd, middle_rd;
   sem_pkg::win_ctrl_type ctrl_ff, ctrl_in;
   logic [71:0] ch_win [3];
   logic [2:0] ch_done;
   logic [7:0] ch_edge [3];
   logic out_valid_ff;
   logic [7:0] out_r_ff, out_g_ff, out_b_ff;
   logic out_last_ff;
   logic req_fire, calc_start;
   logic out_free, out_load;
   logic signed [RW:0] cr, cc;

   // Effective geometry
   always_comb begin
      if (width_ff == 12'd0) w_eff = CW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(width_ff);
      if (height_ff == 13'd0) h_eff = RW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
      else h_eff = RW'(height_ff);
      cur_col = (col_ff >= w_eff) ? '0 : col_ff;
   end

   assign req.ready = (st_ff == sem_pkg::S_IDLE);
   assign req_fire  = req.valid && req.ready;

   // Output register can take a result this cycle
   assign out_free = !out_valid_ff || rsp.ready;
   assign out_load = out_free
                  && (((st_ff == sem_pkg::S_CALC) && ch_done[0]) || (st_ff == sem_pkg::S_HOLD));

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 13'd480;
      end else if (csr_write) begin
         if (csr_index == 1'(sem_pkg::CSR_WIDTH)) width_ff <= csr_data[11:0];
         else height_ff <= csr_data;
      end
   end

   sem_line_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_lines (
      .clock    (clock),
      .rd_en    (req_fire),
      .rd_addr  (AW'(cur_col)),
      .upper_rd (upper_rd),
      .middle_rd(middle_rd),
      .wr_en    (st_ff == sem_pkg::S_READ),
      .wr_addr  (AW'(cur_col)),
      .upper_wr (middle_rd),
      .middle_wr(px_ff)
   );

   // Window center position and neighbor masks
   always_comb begin
      if (cur_col >= CW'(1)) begin
         cc = (RW+1)'(cur_col) - 1;
         cr = signed'((RW+1)'(row_ff)) - 1;
      end else begin
         cc = (RW+1)'(w_eff) - 1;
         cr = signed'((RW+1)'(row_ff)) - 2;
      end
      ctrl_in.emit = (cr >= 0) && (cr < signed'((RW+1)'(h_eff)));
      ctrl_in.last = (cr == signed'((RW+1)'(h_eff)) - 1)
                  && (cc == signed'((RW+1)'(w_eff)) - 1);
      ctrl_in.keep_row[0] = (cr >= 1);
      ctrl_in.keep_row[1] = 1'b1;
      ctrl_in.keep_row[2] = (cr + 1 < signed'((RW+1)'(h_eff)));
      ctrl_in.keep_col[0] = (cc >= 1);
      ctrl_in.keep_col[1] = 1'b1;
      ctrl_in.keep_col[2] = (cc + 1 < signed'((RW+1)'(w_eff)));
      if (cur_col + CW'(1) >= w_eff) begin
         col_in = '0;
         row_in = row_ff + RW'(1);
      end else begin
         col_in = cur_col + CW'(1);
         row_in = row_ff;
      end
      if (ctrl_in.emit && ctrl_in.last) begin
         col_in = '0;
         row_in = '0;
      end
   end

   assign calc_start = (st_ff == sem_pkg::S_WIN) && ctrl_ff.emit;

   // Sequencer
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         sem_pkg::S_IDLE: if (req_fire) st_in = sem_pkg::S_READ;
         sem_pkg::S_READ: st_in = sem_pkg::S_WIN;
         sem_pkg::S_WIN:  st_in = ctrl_ff.emit ? sem_pkg::S_CALC : sem_pkg::S_IDLE;
         sem_pkg::S_CALC: begin
            if (ch_done[0]) st_in = out_free ? sem_pkg::S_IDLE : sem_pkg::S_HOLD;
         end
         sem_pkg::S_HOLD: if (out_free) st_in = sem_pkg::S_IDLE;
         default: st_in = sem_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= sem_pkg::S_IDLE;
         col_ff <= '0;
         row_ff <= '0;
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_write) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (st_ff == sem_pkg::S_READ) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (st_ff == sem_pkg::S_READ) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i*3]   <= win_ff[i*3+1];
               win_ff[i*3+1] <= win_ff[i*3+2];
            end
            win_ff[2] <= upper_rd;
            win_ff[5] <= middle_rd;
            win_ff[8] <= px_ff;
         end
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
      end
      if (req_fire) px_ff <= req.blank ? '0 : {req.red_in, req.green_in, req.blue_in};
      if (st_ff == sem_pkg::S_READ) ctrl_ff <= ctrl_in;
      // Channel results stay put until the next start, so a held result loads late
      if (out_load) begin
         out_r_ff    <= ch_edge[0];
         out_g_ff    <= ch_edge[1];
         out_b_ff    <= ch_edge[2];
         out_last_ff <= ctrl_ff.last;
      end
   end

   // Masked per-channel windows (channel 0 red, 1 green, 2 blue)
   always_comb begin
      for (int c = 0; c < 3; c++)
         for (int k = 0; k < 9; k++)
            ch_win[c][8*k +: 8] = (ctrl_ff.keep_row[k/3] && ctrl_ff.keep_col[k%3])
               ? win_ff[k][8*(2-c) +: 8] : 8'd0;
   end

   for (genvar c = 0; c < 3; c++) begin : g_ch
      sem_magnitude u_mag (
         .clock   (clock),
         .reset   (reset),
         .start   (calc_start),
         .win     (ch_win[c]),
         .done    (ch_done[c]),
         .edge_out(ch_edge[c])
      );
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.red_edge   = out_r_ff;
   assign rsp.green_edge = out_g_ff;
   assign rsp.blue_edge  = out_b_ff;
   assign rsp.frame_end  = out_last_ff;
endmodule
